@@ src/assert_macros.svh @@
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, suspended while reset is high.
`define M3E_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("m3e assertion failed");

// Check a property on every clock edge, reset included.
`define M3E_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("m3e assertion failed");

`endif

@@ src/m3e_pkg.sv @@
// Shared constants and types of the median/EMA ADC filter.
`timescale 1ns / 1ps
`default_nettype none
package m3e_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int FRACTION_BITS = 8;
  localparam int AVG_BITS      = SAMPLE_BITS + FRACTION_BITS;

  // Alpha is Q0.8, one more bit to hold 1.0
  localparam int ALPHA_FRAC = 8;
  localparam int ALPHA_BITS = ALPHA_FRAC + 1;
  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = ALPHA_BITS'(1 << ALPHA_FRAC);

  // Signed product of alpha and the sample/average difference, plus headroom
  localparam int PROD_BITS = AVG_BITS + ALPHA_BITS + 2;

  localparam logic [ALPHA_BITS-1:0] THROTTLE_ALPHA_RESET = ALPHA_BITS'(154);
  localparam logic [ALPHA_BITS-1:0] BRAKE_ALPHA_RESET    = ALPHA_BITS'(77);

  localparam int RING_DEPTH = 3;
  localparam int RING_BITS  = $clog2(RING_DEPTH);
  localparam logic [RING_BITS-1:0] RING_LAST = RING_BITS'(RING_DEPTH - 1);

  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = ALPHA_BITS;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_THROTTLE_ALPHA = 4'd0,
    REG_BRAKE_ALPHA    = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [AVG_BITS-1:0] throttle_filtered;
    logic [AVG_BITS-1:0] brake_filtered;
  } lane_result_t;

endpackage
`default_nettype wire

@@ src/m3e_sample_if.sv @@
// Input channel: one throttle and one brake sample per item.
`timescale 1ns / 1ps
`default_nettype none
interface m3e_sample_if import m3e_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] throttle_sample;
  logic [SAMPLE_BITS-1:0] brake_sample;

  modport source (output valid, output throttle_sample, output brake_sample, input ready);
  modport sink   (input valid, input throttle_sample, input brake_sample, output ready);
endinterface
`default_nettype wire

@@ src/m3e_result_if.sv @@
// Output channel: filtered throttle and brake values in 12.8 fixed point.
`timescale 1ns / 1ps
`default_nettype none
interface m3e_result_if import m3e_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [AVG_BITS-1:0] throttle_filtered;
  logic [AVG_BITS-1:0] brake_filtered;

  modport source (output valid, output throttle_filtered, output brake_filtered, input ready);
  modport sink   (input valid, input throttle_filtered, input brake_filtered, output ready);
endinterface
`default_nettype wire

@@ src/m3e_cfg_if.sv @@
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
`default_nettype none
interface m3e_cfg_if import m3e_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/median3_ema_dual_adc_filter_top.sv @@
// Dual ADC filter: median-of-three plus EMA on throttle, EMA on brake.
//
// Channels: samples carries one throttle and one brake ADC reading per item;
// results carries both smoothed values as unsigned 12.8 fixed point; cfg
// writes throttle_alpha (index 0) or brake_alpha (index 1), Q0.8 where 256
// passes the sample through and larger values act as 256. Other indexes are
// ignored. cfg.ready is always high; write only while the block is idle.
// Each taken item is registered into the output buffer. Throughput: one
// item per cycle unless results.ready stalls. Each lane updates its average
// with one multiply, and the throttle median feeds it combinationally.
// Reset (rst, synchronous) empties the ring and the output buffer, unseeds
// both averages and loads alpha 154 and 77.
// Stall: when results.ready is low, one more item is parked in a skid
// entry; after that samples.ready drops until the receiver takes an item.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module median3_ema_dual_adc_filter_top import m3e_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  m3e_sample_if.sink   samples,
  m3e_result_if.source results,
  m3e_cfg_if.sink      cfg
);

  logic [ALPHA_BITS-1:0]  throttle_alpha;
  logic [ALPHA_BITS-1:0]  brake_alpha;
  logic                   in_fire;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] throttle_clean;
  logic [AVG_BITS-1:0]    throttle_next;
  logic [AVG_BITS-1:0]    brake_next;
  lane_result_t           lanes;

  assign cfg.ready     = 1'b1;
  assign samples.ready = in_ready;
  assign in_fire       = samples.valid && in_ready;
  assign lanes         = '{throttle_filtered: throttle_next, brake_filtered: brake_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_alpha <= THROTTLE_ALPHA_RESET;
      brake_alpha    <= BRAKE_ALPHA_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_THROTTLE_ALPHA: throttle_alpha <= cfg.data;
        REG_BRAKE_ALPHA:    brake_alpha    <= cfg.data;
        default: ;
      endcase
    end
  end

  m3e_median3 u_median3 (
    .clk    (clk),
    .rst    (rst),
    .fire   (in_fire),
    .sample (samples.throttle_sample),
    .clean  (throttle_clean)
  );

  m3e_ema_lane u_throttle_lane (
    .clk      (clk),
    .rst      (rst),
    .fire     (in_fire),
    .alpha    (throttle_alpha),
    .x        (throttle_clean),
    .avg_next (throttle_next)
  );

  m3e_ema_lane u_brake_lane (
    .clk      (clk),
    .rst      (rst),
    .fire     (in_fire),
    .alpha    (brake_alpha),
    .x        (samples.brake_sample),
    .avg_next (brake_next)
  );

  m3e_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .lanes    (lanes),
    .in_ready (in_ready),
    .results  (results)
  );

  // input backpressure only while a result waits at the output
  `M3E_ASSERT(a_stall_has_result, clk, rst, !samples.ready |-> results.valid)
  // an item taken into an empty output shows up on the next cycle
  `M3E_ASSERT(a_item_reaches_output, clk, rst, (in_fire && !results.valid) |=> results.valid)
  // reset leaves the output empty and the input open
  `M3E_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> (!results.valid && samples.ready))

endmodule
`default_nettype wire

@@ src/m3e_median3.sv @@
// Three-entry throttle sample ring and median selection.
`timescale 1ns / 1ps
`default_nettype none
module m3e_median3 import m3e_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   fire,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic      [SAMPLE_BITS-1:0] clean
);

  logic [SAMPLE_BITS-1:0] ring      [RING_DEPTH];
  logic [SAMPLE_BITS-1:0] ring_next [RING_DEPTH];
  logic [RING_BITS-1:0]   ring_position;
  logic [RING_BITS-1:0]   ring_position_next;
  logic                   ring_filled;
  logic                   ring_filled_next;
  logic [SAMPLE_BITS-1:0] lo_ab;
  logic [SAMPLE_BITS-1:0] hi_ab;
  logic [SAMPLE_BITS-1:0] hi_min_c;
  logic [SAMPLE_BITS-1:0] median;

  always_comb begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_next[i] = (ring_position == RING_BITS'(i)) ? sample : ring[i];
    end
    ring_position_next = (ring_position == RING_LAST) ? '0 : ring_position + 1'b1;
    ring_filled_next   = ring_filled | (ring_position == RING_LAST);
  end

  // median = max(min(a, b), min(max(a, b), c))
  always_comb begin
    lo_ab    = (ring_next[0] < ring_next[1]) ? ring_next[0] : ring_next[1];
    hi_ab    = (ring_next[0] < ring_next[1]) ? ring_next[1] : ring_next[0];
    hi_min_c = (hi_ab < ring_next[2]) ? hi_ab : ring_next[2];
    median   = (lo_ab > hi_min_c) ? lo_ab : hi_min_c;
    clean    = ring_filled_next ? median : sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring[i] <= '0;
      end
      ring_position <= '0;
      ring_filled   <= 1'b0;
    end else if (fire) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring[i] <= ring_next[i];
      end
      ring_position <= ring_position_next;
      ring_filled   <= ring_filled_next;
    end
  end

endmodule
`default_nettype wire

@@ src/m3e_ema_lane.sv @@
// One EMA lane: seed on the first sample, then blend with a single multiply.
`timescale 1ns / 1ps
`default_nettype none
module m3e_ema_lane import m3e_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   fire,
  input  wire logic [ALPHA_BITS-1:0]  alpha,
  input  wire logic [SAMPLE_BITS-1:0] x,
  output logic      [AVG_BITS-1:0]    avg_next
);

  logic                        seeded;
  logic [AVG_BITS-1:0]         avg;
  logic [ALPHA_BITS-1:0]       alpha_sat;
  logic [AVG_BITS-1:0]         scaled;
  logic signed [AVG_BITS:0]    diff;
  logic signed [ALPHA_BITS:0]  alpha_s;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [PROD_BITS-1:0] base;
  logic signed [PROD_BITS-1:0] total;

  // a*x + (1-a)*s  ==  s + a*(x - s), kept exact before the truncating shift
  always_comb begin
    alpha_sat = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
    scaled    = {x, {FRACTION_BITS{1'b0}}};
    diff      = $signed({1'b0, scaled}) - $signed({1'b0, avg});
    alpha_s   = $signed({1'b0, alpha_sat});
    prod      = alpha_s * diff;
    base      = $signed({{(PROD_BITS - AVG_BITS - ALPHA_FRAC){1'b0}}, avg,
                         {ALPHA_FRAC{1'b0}}});
    total     = base + prod;
    avg_next  = seeded ? total[ALPHA_FRAC +: AVG_BITS] : scaled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded <= 1'b0;
      avg    <= '0;
    end else if (fire) begin
      seeded <= 1'b1;
      avg    <= avg_next;
    end
  end

endmodule
`default_nettype wire

@@ src/m3e_merge.sv @@
// Merge the lane results into one item behind a two-entry skid buffer.
`timescale 1ns / 1ps
`default_nettype none
module m3e_merge import m3e_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_fire,
  input  wire lane_result_t lanes,
  output logic              in_ready,
  m3e_result_if.source      results
);

  lane_result_t main;
  lane_result_t skid;
  logic         main_valid;
  logic         skid_valid;
  logic         out_fire;

  assign out_fire                  = main_valid && results.ready;
  assign in_ready                  = !skid_valid;
  assign results.valid             = main_valid;
  assign results.throttle_filtered = main.throttle_filtered;
  assign results.brake_filtered    = main.brake_filtered;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // advance the parked item once the head is taken
      if (out_fire) begin
        main       <= skid;
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (!main_valid || out_fire) begin
        main       <= lanes;
        main_valid <= 1'b1;
      end else begin
        skid       <= lanes;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      main_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire
